/* src/pfit_pkg.sv */
// ----------------------------------------------------------------------------
// pfit_pkg
// Shared constants, codes and controller command type for the plane fit unit.
// ----------------------------------------------------------------------------
package pfit_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int RES_BITS           = 54;
  localparam int TOL_BITS           = 16;
  localparam int FUNC_BITS          = 2;
  localparam int IDX_BITS           = 2;
  localparam int POINT_COUNT        = 3;

  localparam logic [TOL_BITS-1:0] TOL_RESET       = 16'd5;
  localparam logic [IDX_BITS-1:0] POINT_INDEX_MAX = 2'd2;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_COMPUTE = 2'd1,
    FUNC_TEST    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE,
    ST_CROSS_A,
    ST_CROSS_B,
    ST_NORM,
    ST_MUL_OFF,
    ST_OFFSET,
    ST_TEST_MUL,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_CROSS_A,
    MUL_CROSS_B,
    MUL_OFFSET,
    MUL_TEST
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     load_point;
    logic     edge_en;
    mul_sel_t mul_sel;
    logic     norm_first;
    logic     norm_sub;
    logic     degen_en;
    logic     offset_en;
    logic     out_load;
  } cmd_t;

endpackage

/* src/pfit_ctrl.sv */
// ----------------------------------------------------------------------------
// pfit_ctrl
// Sequencer for the plane fit unit: input and output handshakes and the
// step order for load, compute and test beats.
// ----------------------------------------------------------------------------
module pfit_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [pfit_pkg::FUNC_BITS-1:0] func,
  input  logic                           out_stall,
  output logic                           in_stall,
  output logic                           out_valid,
  output pfit_pkg::cmd_t                 cmd
);

  pfit_pkg::state_t state;
  pfit_pkg::state_t state_next;
  logic             out_valid_next;
  logic             out_free;
  logic             fin_go;
  logic             in_accept;
  pfit_pkg::state_t dispatch;

  assign out_free  = !out_valid || !out_stall;
  assign fin_go    = (state == pfit_pkg::ST_FIN) && out_free;
  assign in_stall  = !((state == pfit_pkg::ST_IDLE) || fin_go);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    case (pfit_pkg::func_t'(func))
      pfit_pkg::FUNC_COMPUTE: dispatch = pfit_pkg::ST_EDGE;
      pfit_pkg::FUNC_TEST:    dispatch = pfit_pkg::ST_TEST_MUL;
      default:                dispatch = pfit_pkg::ST_FIN;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      pfit_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = dispatch;
        end
      end
      pfit_pkg::ST_EDGE:     state_next = pfit_pkg::ST_CROSS_A;
      pfit_pkg::ST_CROSS_A:  state_next = pfit_pkg::ST_CROSS_B;
      pfit_pkg::ST_CROSS_B:  state_next = pfit_pkg::ST_NORM;
      pfit_pkg::ST_NORM:     state_next = pfit_pkg::ST_MUL_OFF;
      pfit_pkg::ST_MUL_OFF:  state_next = pfit_pkg::ST_OFFSET;
      pfit_pkg::ST_OFFSET:   state_next = pfit_pkg::ST_FIN;
      pfit_pkg::ST_TEST_MUL: state_next = pfit_pkg::ST_FIN;
      pfit_pkg::ST_FIN: begin
        if (fin_go) begin
          state_next = in_accept ? dispatch : pfit_pkg::ST_IDLE;
        end
      end
      default: state_next = pfit_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.mul_sel    = pfit_pkg::MUL_NONE;
    cmd.capture    = in_accept;
    cmd.load_point = fin_go;
    cmd.out_load   = fin_go;
    case (state)
      pfit_pkg::ST_EDGE:     cmd.edge_en = 1'b1;
      pfit_pkg::ST_CROSS_A:  cmd.mul_sel = pfit_pkg::MUL_CROSS_A;
      pfit_pkg::ST_CROSS_B: begin
        cmd.mul_sel    = pfit_pkg::MUL_CROSS_B;
        cmd.norm_first = 1'b1;
      end
      pfit_pkg::ST_NORM:     cmd.norm_sub = 1'b1;
      pfit_pkg::ST_MUL_OFF: begin
        cmd.mul_sel  = pfit_pkg::MUL_OFFSET;
        cmd.degen_en = 1'b1;
      end
      pfit_pkg::ST_OFFSET:   cmd.offset_en = 1'b1;
      pfit_pkg::ST_TEST_MUL: cmd.mul_sel = pfit_pkg::MUL_TEST;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (fin_go) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfit_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* src/pfit_datapath.sv */
// ----------------------------------------------------------------------------
// pfit_datapath
// Sample points, plane registers, three shared multiplier lanes, residual
// adder, tolerance compare and the result register.
// ----------------------------------------------------------------------------
module pfit_datapath #(
  parameter int COORD_BITS = pfit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pfit_pkg::cmd_t                      cmd,
  input  logic [pfit_pkg::FUNC_BITS-1:0]      func,
  input  logic [pfit_pkg::IDX_BITS-1:0]       point_index,
  input  logic signed [COORD_BITS-1:0]        coord_x,
  input  logic signed [COORD_BITS-1:0]        coord_y,
  input  logic signed [COORD_BITS-1:0]        coord_z,
  input  logic                                cfg_we,
  input  logic [pfit_pkg::TOL_BITS-1:0]       cfg_wdata,
  output logic                                error,
  output logic                                inlier,
  output logic signed [pfit_pkg::RES_BITS-1:0] residual
);

  localparam int EDGE_W = COORD_BITS + 1;
  localparam int NORM_W = 2 * COORD_BITS + 3;
  localparam int PROD_W = EDGE_W + NORM_W;
  localparam int ACC_W  = (PROD_W > pfit_pkg::RES_BITS) ? PROD_W : pfit_pkg::RES_BITS;
  localparam int RES_W  = pfit_pkg::RES_BITS;

  pfit_pkg::func_t                  op_func;
  logic [pfit_pkg::IDX_BITS-1:0]    op_idx;
  logic signed [COORD_BITS-1:0]     op_coord [pfit_pkg::POINT_COUNT];
  logic signed [COORD_BITS-1:0]     sample   [pfit_pkg::POINT_COUNT][pfit_pkg::POINT_COUNT];
  logic signed [EDGE_W-1:0]         edge_u   [pfit_pkg::POINT_COUNT];
  logic signed [EDGE_W-1:0]         edge_v   [pfit_pkg::POINT_COUNT];
  logic signed [NORM_W-1:0]         normal   [pfit_pkg::POINT_COUNT];
  logic signed [PROD_W-1:0]         prod     [pfit_pkg::POINT_COUNT];
  logic signed [ACC_W-1:0]          prod_x   [pfit_pkg::POINT_COUNT];
  logic signed [RES_W-1:0]          offset;
  logic                             degen;
  logic [pfit_pkg::TOL_BITS-1:0]    tolerance;
  logic signed [ACC_W-1:0]          prod_sum;
  logic signed [ACC_W-1:0]          neg_sum;
  logic signed [ACC_W-1:0]          res_sum;
  logic signed [RES_W-1:0]          res_val;
  logic signed [RES_W:0]            res_w;
  logic signed [RES_W:0]            tol_pos;
  logic signed [RES_W:0]            tol_neg;
  logic                             in_tol;
  logic                             load_ok;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func     <= pfit_pkg::func_t'(func);
      op_idx      <= point_index;
      op_coord[0] <= coord_x;
      op_coord[1] <= coord_y;
      op_coord[2] <= coord_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= pfit_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  assign load_ok = (op_idx <= pfit_pkg::POINT_INDEX_MAX);

  // sample point store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < pfit_pkg::POINT_COUNT; p++) begin
        for (int c = 0; c < pfit_pkg::POINT_COUNT; c++) begin
          sample[p][c] <= '1;
        end
      end
    end else if (cmd.load_point && (op_func == pfit_pkg::FUNC_LOAD) && load_ok) begin
      for (int p = 0; p < pfit_pkg::POINT_COUNT; p++) begin
        if (op_idx == pfit_pkg::IDX_BITS'(p)) begin
          for (int c = 0; c < pfit_pkg::POINT_COUNT; c++) begin
            sample[p][c] <= op_coord[c];
          end
        end
      end
    end
  end

  // multiplier lanes
  for (genvar i = 0; i < pfit_pkg::POINT_COUNT; i++) begin : g_lane
    localparam int J = (i + 1) % pfit_pkg::POINT_COUNT;
    localparam int K = (i + 2) % pfit_pkg::POINT_COUNT;

    logic signed [EDGE_W-1:0] mul_a;
    logic signed [NORM_W-1:0] mul_b;

    always_comb begin
      case (cmd.mul_sel)
        pfit_pkg::MUL_CROSS_A: begin
          mul_a = edge_u[J];
          mul_b = NORM_W'(edge_v[K]);
        end
        pfit_pkg::MUL_CROSS_B: begin
          mul_a = edge_u[K];
          mul_b = NORM_W'(edge_v[J]);
        end
        pfit_pkg::MUL_OFFSET: begin
          mul_a = EDGE_W'(sample[1][i]);
          mul_b = normal[i];
        end
        pfit_pkg::MUL_TEST: begin
          mul_a = EDGE_W'(op_coord[i]);
          mul_b = normal[i];
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (cmd.edge_en) begin
        edge_u[i] <= EDGE_W'(sample[1][i]) - EDGE_W'(sample[0][i]);
        edge_v[i] <= EDGE_W'(sample[2][i]) - EDGE_W'(sample[0][i]);
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.mul_sel != pfit_pkg::MUL_NONE) begin
        prod[i] <= mul_a * mul_b;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        normal[i] <= '0;
      end else if (cmd.norm_first) begin
        normal[i] <= prod[i][NORM_W-1:0];
      end else if (cmd.norm_sub) begin
        normal[i] <= normal[i] - prod[i][NORM_W-1:0];
      end
    end

    assign prod_x[i] = ACC_W'(prod[i]);
  end

  assign prod_sum = prod_x[0] + prod_x[1] + prod_x[2];
  assign neg_sum  = -prod_sum;
  assign res_sum  = prod_sum + ACC_W'(offset);
  assign res_val  = res_sum[RES_W-1:0];
  assign res_w    = (RES_W + 1)'(res_val);
  assign tol_pos  = (RES_W + 1)'(tolerance);
  assign tol_neg  = -tol_pos;
  assign in_tol   = (res_w < tol_pos) && (res_w > tol_neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cmd.offset_en) begin
      offset <= neg_sum[RES_W-1:0];
    end
  end

  // a zero normal flags the compute result as an error
  always_ff @(posedge clk) begin
    if (cmd.degen_en) begin
      degen <= (normal[0] == '0) && (normal[1] == '0) && (normal[2] == '0);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (op_func)
        pfit_pkg::FUNC_LOAD: begin
          error    <= !load_ok;
          inlier   <= 1'b0;
          residual <= '0;
        end
        pfit_pkg::FUNC_COMPUTE: begin
          error    <= degen;
          inlier   <= 1'b0;
          residual <= '0;
        end
        pfit_pkg::FUNC_TEST: begin
          error    <= 1'b0;
          inlier   <= in_tol;
          residual <= res_val;
        end
        default: begin
          error    <= 1'b0;
          inlier   <= 1'b0;
          residual <= '0;
        end
      endcase
    end
  end

endmodule

/* src/plane_fit_point_inlier_test_unit.sv */
// ----------------------------------------------------------------------------
// plane_fit_point_inlier_test_unit
// Integer plane fit from three sample points and point inlier test.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A load or unused beat goes straight to the result
// register, a test beat multiplies through the three shared multiplier lanes,
// then does the residual add and tolerance compare, and a compute beat steps
// through edges, two rounds of cross-product terms through the same three lanes,
// normal subtract, offset products, offset sum and result. The next beat is
// taken in the cycle its predecessor's result is registered, so a stream of
// test beats runs with no idle step between points while the output side keeps up.
// The result register holds a beat while the output stalls.
module plane_fit_point_inlier_test_unit #(
  parameter int COORD_BITS = pfit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pfit_pkg::FUNC_BITS-1:0]       func,
  input  logic [pfit_pkg::IDX_BITS-1:0]        point_index,
  input  logic signed [COORD_BITS-1:0]         coord_x,
  input  logic signed [COORD_BITS-1:0]         coord_y,
  input  logic signed [COORD_BITS-1:0]         coord_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 error,
  output logic                                 inlier,
  output logic signed [pfit_pkg::RES_BITS-1:0] residual,
  input  logic                                 cfg_we,
  input  logic [pfit_pkg::TOL_BITS-1:0]        cfg_wdata
);

  pfit_pkg::cmd_t cmd;

  pfit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pfit_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (func),
    .point_index (point_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .error       (error),
    .inlier      (inlier),
    .residual    (residual)
  );

endmodule

/* src/pfit_checker.sv */
// ----------------------------------------------------------------------------
// pfit_checker
// Port-level checks for the plane fit unit, bound to the top level.
// ----------------------------------------------------------------------------
module pfit_checker #(
  parameter int COORD_BITS = pfit_pkg::COORD_BITS_DEFAULT
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [pfit_pkg::FUNC_BITS-1:0]       func,
  input logic [pfit_pkg::IDX_BITS-1:0]        point_index,
  input logic signed [COORD_BITS-1:0]         coord_x,
  input logic signed [COORD_BITS-1:0]         coord_y,
  input logic signed [COORD_BITS-1:0]         coord_z,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 error,
  input logic                                 inlier,
  input logic signed [pfit_pkg::RES_BITS-1:0] residual
);

  a_reset_no_beat: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(func) && $stable(point_index)
      && $stable(coord_x) && $stable(coord_y) && $stable(coord_z))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(error) && $stable(inlier)
      && $stable(residual))
    else $error("stalled result beat changed");

  a_inlier_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && inlier |-> !error)
    else $error("inlier and error on one beat");

  a_residual_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (residual != '0) |-> !error)
    else $error("residual on an error beat");

endmodule

bind plane_fit_point_inlier_test_unit pfit_checker #(
  .COORD_BITS (COORD_BITS)
) u_pfit_checker (.*);
